// ===== rtl/core/afm_pkg.sv =====
package afm_pkg;

  // One input item: three signed Q8.8 channels.
  typedef struct packed {
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
  } pix_in_t;

  // One result item: three Q1.12 channels, 4096 is 1.0.
  typedef struct packed {
    logic [12:0] red_out;
    logic [12:0] green_out;
    logic [12:0] blue_out;
  } pix_out_t;

  localparam int unsigned InW   = 16;
  localparam int unsigned OutW  = 13;
  localparam int unsigned UW    = 17;
  localparam int unsigned SqW   = 34;
  localparam int unsigned PolyW = 42;
  localparam int unsigned RemW  = 56;

  // Curve coefficients, scaled so that v = u / 1280 with u = 3 * x.
  localparam logic [PolyW-1:0] NumA = 42'd251;
  localparam logic [PolyW-1:0] NumB = 42'd3840;
  localparam logic [PolyW-1:0] DenA = 42'd243;
  localparam logic [PolyW-1:0] DenB = 42'd75520;
  localparam logic [PolyW-1:0] DenC = 42'd22937600;

  localparam logic [OutW-1:0] OneQ12 = 13'd4096;

endpackage

// ===== rtl/core/afm_front.sv =====
module afm_front import afm_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [InW-1:0]  x_i,
  output logic [RemW-1:0]        a_o,
  output logic [PolyW-1:0]       den_o
);

  logic [UW-1:0]    u_q, u2_q;
  logic [SqW-1:0]   sq_q;
  logic [PolyW-1:0] num_q, den_q, den4_q;
  logic [RemW-1:0]  a_q;

  // Stage 1: clamp negatives to zero and scale by three.
  always_ff @(posedge clk_i) begin
    if (x_i[InW-1]) begin
      u_q <= '0;
    end else begin
      u_q <= {1'b0, x_i[InW-1:0]} + {x_i[InW-1:0], 1'b0};
    end
  end

  // Stage 2: square.
  always_ff @(posedge clk_i) begin
    sq_q <= SqW'(u_q) * SqW'(u_q);
    u2_q <= u_q;
  end

  // Stage 3: numerator and denominator polynomials.
  always_ff @(posedge clk_i) begin
    num_q <= NumA * PolyW'(sq_q) + NumB * PolyW'(u2_q);
    den_q <= DenA * PolyW'(sq_q) + DenB * PolyW'(u2_q) + DenC;
  end

  // Stage 4: dividend scaled to Q12 with half the divisor added for rounding.
  always_ff @(posedge clk_i) begin
    a_q    <= {num_q, 12'd0} + RemW'(den_q >> 1);
    den4_q <= den_q;
  end

  assign a_o   = a_q;
  assign den_o = den4_q;

endmodule

// ===== rtl/core/afm_div_stage.sv =====
module afm_div_stage import afm_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic             clk_i,
  input  logic [RemW-1:0]  r_i,
  input  logic [PolyW-1:0] den_i,
  input  logic [OutW-1:0]  q_i,
  output logic [RemW-1:0]  r_o,
  output logic [PolyW-1:0] den_o,
  output logic [OutW-1:0]  q_o
);

  logic [RemW-1:0] dsh;
  logic            ge;

  // One restoring step: try to take the shifted divisor off the remainder.
  assign dsh = RemW'(den_i) << Shift;
  assign ge  = (r_i >= dsh);

  always_ff @(posedge clk_i) begin
    r_o   <= ge ? (r_i - dsh) : r_i;
    den_o <= den_i;
    q_o   <= q_i | (ge ? (OutW'(1) << Shift) : '0);
  end

endmodule

// ===== rtl/core/aces_filmic_tone_map_top.sv =====
// ACES filmic tone map: one RGB pixel in signed Q8.8 per cycle, one pixel out in Q1.12
// (4096 is 1.0) per cycle. An item accepted with start_i shows up on pix_o with done_o
// high after the front end (clamp and scale, square, polynomials, rounded dividend) and
// a 13-step restoring divider, one quotient bit per stage, plus an output saturation
// register. busy_o stays low, so a new item may enter in every cycle. The receiver cannot
// stall the output: each result is on pix_o for the single cycle in which done_o is high.
module aces_filmic_tone_map_top import afm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  pix_in_t  pix_i,
  output logic     done_o,
  output pix_out_t pix_o
);

  localparam int unsigned Lat = 4 + OutW + 1;

  logic [Lat-1:0]       vld_q;
  logic signed [InW-1:0] x_ch [3];
  logic [OutW-1:0]       y_ch [3];
  logic [OutW-1:0]       res_q [3];

  assign busy_o = 1'b0;
  assign x_ch[0] = pix_i.red_in;
  assign x_ch[1] = pix_i.green_in;
  assign x_ch[2] = pix_i.blue_in;

  // Valid bits follow the items down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end

  // One lane per channel: front end, divider chain, saturation.
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [RemW-1:0]  r  [OutW+1];
    logic [PolyW-1:0] d  [OutW+1];
    logic [OutW-1:0]  q  [OutW+1];

    afm_front u_front (
      .clk_i (clk_i),
      .x_i   (x_ch[c]),
      .a_o   (r[0]),
      .den_o (d[0])
    );
    assign q[0] = '0;

    for (genvar s = 0; s < OutW; s++) begin : g_div
      afm_div_stage #(.Shift(OutW - 1 - s)) u_div (
        .clk_i (clk_i),
        .r_i   (r[s]),
        .den_i (d[s]),
        .q_i   (q[s]),
        .r_o   (r[s+1]),
        .den_o (d[s+1]),
        .q_o   (q[s+1])
      );
    end

    // Saturate above 1.0.
    always_ff @(posedge clk_i) begin
      res_q[c] <= (q[OutW] > OneQ12) ? OneQ12 : q[OutW];
    end
    assign y_ch[c] = res_q[c];
  end

  assign done_o          = vld_q[Lat-1];
  assign pix_o.red_out   = y_ch[0];
  assign pix_o.green_out = y_ch[1];
  assign pix_o.blue_out  = y_ch[2];

endmodule
